>>> hw/rtl/pfcs_pkg.sv
// Package for the parallel flash command sequencer: types, codes and microcode.
package pfcs_pkg;

  localparam int ADDR_WIDTH_DEF = 19;
  localparam int BUS_ADDR_W     = 19;
  localparam int DATA_W         = 16;
  localparam int PC_W           = 5;

  typedef logic [PC_W-1:0] pc_t;

  localparam logic [2:0] MODE_READ     = 3'd0;
  localparam logic [2:0] MODE_PROGRAM  = 3'd1;
  localparam logic [2:0] MODE_ERASE    = 3'd2;
  localparam logic [2:0] MODE_IDENTIFY = 3'd3;
  localparam logic [2:0] MODE_EXIT     = 3'd4;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WAIT  = 2'd2;

  localparam logic [BUS_ADDR_W-1:0] UNLOCK_A = 19'h05555;
  localparam logic [BUS_ADDR_W-1:0] UNLOCK_B = 19'h02AAA;

  localparam logic [7:0] CMD_AA    = 8'hAA;
  localparam logic [7:0] CMD_55    = 8'h55;
  localparam logic [7:0] CMD_PROG  = 8'hA0;
  localparam logic [7:0] CMD_ERASE = 8'h80;
  localparam logic [7:0] CMD_CHIP  = 8'h10;
  localparam logic [7:0] CMD_ID    = 8'h90;
  localparam logic [7:0] CMD_EXIT  = 8'hF0;

  localparam pc_t PC_READ     = 5'd0;
  localparam pc_t PC_PROGRAM  = 5'd1;
  localparam pc_t PC_ERASE    = 5'd5;
  localparam pc_t PC_IDENTIFY = 5'd12;
  localparam pc_t PC_EXIT     = 5'd17;
  localparam pc_t PC_MAX      = 5'd19;

  typedef enum logic [2:0] {
    ASEL_ZERO,
    ASEL_ONE,
    ASEL_UNLOCK_A,
    ASEL_UNLOCK_B,
    ASEL_TARGET
  } asel_t;

  typedef enum logic [1:0] {
    DSEL_ZERO,
    DSEL_CMD,
    DSEL_WORD
  } dsel_t;

  typedef struct packed {
    logic [2:0]            mode;
    logic [BUS_ADDR_W-1:0] target_address;
    logic [DATA_W-1:0]     write_word;
  } in_t;

  typedef struct packed {
    logic [1:0]            cycle_kind;
    logic [BUS_ADDR_W-1:0] bus_address;
    logic [DATA_W-1:0]     bus_data;
    logic                  last_cycle;
  } out_t;

  typedef struct packed {
    logic [1:0] kind;
    asel_t      asel;
    dsel_t      dsel;
    logic [7:0] cmd;
    logic       last;
  } uword_t;

  typedef struct packed {
    logic   valid;
    pc_t    pc;
  } entry_t;

  typedef struct packed {
    logic   load;
    logic   emit;
    uword_t uw;
  } ctl_t;

  function automatic uword_t uw(input logic [1:0] kind, input asel_t asel,
                                input dsel_t dsel, input logic [7:0] cmd,
                                input logic last);
    uword_t w;
    w.kind = kind;
    w.asel = asel;
    w.dsel = dsel;
    w.cmd  = cmd;
    w.last = last;
    return w;
  endfunction

  function automatic uword_t rom(input pc_t pc);
    uword_t w;
    unique case (pc)
      5'd0:  w = uw(KIND_READ,  ASEL_TARGET,   DSEL_ZERO, 8'h00,     1'b1);
      5'd1:  w = uw(KIND_WRITE, ASEL_UNLOCK_A, DSEL_CMD,  CMD_AA,    1'b0);
      5'd2:  w = uw(KIND_WRITE, ASEL_UNLOCK_B, DSEL_CMD,  CMD_55,    1'b0);
      5'd3:  w = uw(KIND_WRITE, ASEL_UNLOCK_A, DSEL_CMD,  CMD_PROG,  1'b0);
      5'd4:  w = uw(KIND_WRITE, ASEL_TARGET,   DSEL_WORD, 8'h00,     1'b1);
      5'd5:  w = uw(KIND_WRITE, ASEL_UNLOCK_A, DSEL_CMD,  CMD_AA,    1'b0);
      5'd6:  w = uw(KIND_WRITE, ASEL_UNLOCK_B, DSEL_CMD,  CMD_55,    1'b0);
      5'd7:  w = uw(KIND_WRITE, ASEL_UNLOCK_A, DSEL_CMD,  CMD_ERASE, 1'b0);
      5'd8:  w = uw(KIND_WRITE, ASEL_UNLOCK_A, DSEL_CMD,  CMD_AA,    1'b0);
      5'd9:  w = uw(KIND_WRITE, ASEL_UNLOCK_B, DSEL_CMD,  CMD_55,    1'b0);
      5'd10: w = uw(KIND_WRITE, ASEL_UNLOCK_A, DSEL_CMD,  CMD_CHIP,  1'b0);
      5'd11: w = uw(KIND_WAIT,  ASEL_ZERO,     DSEL_ZERO, 8'h00,     1'b1);
      5'd12: w = uw(KIND_WRITE, ASEL_UNLOCK_A, DSEL_CMD,  CMD_AA,    1'b0);
      5'd13: w = uw(KIND_WRITE, ASEL_UNLOCK_B, DSEL_CMD,  CMD_55,    1'b0);
      5'd14: w = uw(KIND_WRITE, ASEL_UNLOCK_A, DSEL_CMD,  CMD_ID,    1'b0);
      5'd15: w = uw(KIND_READ,  ASEL_ZERO,     DSEL_ZERO, 8'h00,     1'b0);
      5'd16: w = uw(KIND_READ,  ASEL_ONE,      DSEL_ZERO, 8'h00,     1'b0);
      5'd17: w = uw(KIND_WRITE, ASEL_UNLOCK_A, DSEL_CMD,  CMD_AA,    1'b0);
      5'd18: w = uw(KIND_WRITE, ASEL_UNLOCK_B, DSEL_CMD,  CMD_55,    1'b0);
      5'd19: w = uw(KIND_WRITE, ASEL_UNLOCK_A, DSEL_CMD,  CMD_EXIT,  1'b1);
      default: w = uw(KIND_WAIT, ASEL_ZERO,    DSEL_ZERO, 8'h00,     1'b1);
    endcase
    return w;
  endfunction

  function automatic entry_t entry(input logic [2:0] mode);
    entry_t e;
    e.valid = 1'b1;
    unique case (mode)
      MODE_READ:     e.pc = PC_READ;
      MODE_PROGRAM:  e.pc = PC_PROGRAM;
      MODE_ERASE:    e.pc = PC_ERASE;
      MODE_IDENTIFY: e.pc = PC_IDENTIFY;
      MODE_EXIT:     e.pc = PC_EXIT;
      default: begin
        e.valid = 1'b0;
        e.pc    = PC_READ;
      end
    endcase
    return e;
  endfunction

endpackage

>>> hw/rtl/parallel_flash_command_sequencer_top.sv
// Top level of the parallel flash command sequencer.
// A command is taken when start is high and busy is low, and is expanded into one bus cycle
// item per clock on out_data, each marked by a one-cycle out_valid strobe that cannot be held
// off. Read takes 1 bus cycle, exit identify 3, program 4, chip erase 7 and identify 8; busy
// is high from the accept edge until the edge that loads the final item, while the microcode
// step counter advances one step per clock. Unknown modes are taken and produce nothing. The
// final item of each command has last_cycle set.
module parallel_flash_command_sequencer_top #(
  parameter int ADDR_WIDTH = pfcs_pkg::ADDR_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  pfcs_pkg::in_t  in_data,
  output logic           out_valid,
  output pfcs_pkg::out_t out_data
);

  pfcs_pkg::ctl_t ctl;

  pfcs_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_data.mode),
    .busy  (busy),
    .ctl   (ctl)
  );

  pfcs_dpath #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("item strobed without an active command");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_cycle |-> !busy)
    else $error("final item strobed while still busy");

endmodule

>>> hw/rtl/pfcs_useq.sv
// Microcode sequencer: dispatch on the command, step counter and microcode fetch.
module pfcs_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2:0]      mode,
  output logic            busy,
  output pfcs_pkg::ctl_t  ctl
);

  logic             busy_r, busy_nxt;
  pfcs_pkg::pc_t    pc_r, pc_nxt;
  pfcs_pkg::entry_t ent;
  pfcs_pkg::uword_t uw_cur;
  logic             accept;

  assign ent    = pfcs_pkg::entry(mode);
  assign uw_cur = pfcs_pkg::rom(pc_r);
  assign accept = start && !busy_r;

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (accept) begin
      busy_nxt = ent.valid;
      pc_nxt   = ent.pc;
    end else if (busy_r) begin
      if (uw_cur.last) begin
        busy_nxt = 1'b0;
      end else begin
        pc_nxt = pc_r + pfcs_pkg::pc_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= pfcs_pkg::PC_READ;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign busy     = busy_r;
  assign ctl.load = accept;
  assign ctl.emit = busy_r;
  assign ctl.uw   = uw_cur;

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && uw_cur.last |=> !busy_r)
    else $error("sequencer stayed busy after the final step");

  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ent.valid |=> busy_r && pc_r == $past(ent.pc))
    else $error("command did not dispatch to its entry step");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pc_r <= pfcs_pkg::PC_MAX)
    else $error("step counter ran past the microcode");

endmodule

>>> hw/rtl/pfcs_dpath.sv
// Datapath: operand registers, address and data selection, result register.
module pfcs_dpath #(
  parameter int ADDR_WIDTH = pfcs_pkg::ADDR_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pfcs_pkg::in_t  in_data,
  input  pfcs_pkg::ctl_t ctl,
  output logic           out_valid,
  output pfcs_pkg::out_t out_data
);

  localparam logic [pfcs_pkg::BUS_ADDR_W-1:0] AddrMask =
    (pfcs_pkg::BUS_ADDR_W'(1) << ADDR_WIDTH) - pfcs_pkg::BUS_ADDR_W'(1);

  logic [pfcs_pkg::BUS_ADDR_W-1:0] addr_r;
  logic [pfcs_pkg::DATA_W-1:0]     word_r;
  logic                            out_valid_r;
  pfcs_pkg::out_t                  out_r, out_nxt;
  logic [pfcs_pkg::BUS_ADDR_W-1:0] addr_sel;
  logic [pfcs_pkg::DATA_W-1:0]     data_sel;

  always_comb begin
    unique case (ctl.uw.asel)
      pfcs_pkg::ASEL_ZERO:     addr_sel = '0;
      pfcs_pkg::ASEL_ONE:      addr_sel = pfcs_pkg::BUS_ADDR_W'(1);
      pfcs_pkg::ASEL_UNLOCK_A: addr_sel = pfcs_pkg::UNLOCK_A;
      pfcs_pkg::ASEL_UNLOCK_B: addr_sel = pfcs_pkg::UNLOCK_B;
      pfcs_pkg::ASEL_TARGET:   addr_sel = addr_r;
      default:                 addr_sel = '0;
    endcase
    unique case (ctl.uw.dsel)
      pfcs_pkg::DSEL_ZERO: data_sel = '0;
      pfcs_pkg::DSEL_CMD:  data_sel = {ctl.uw.cmd, ctl.uw.cmd};
      pfcs_pkg::DSEL_WORD: data_sel = word_r;
      default:             data_sel = '0;
    endcase
    out_nxt.cycle_kind  = ctl.uw.kind;
    out_nxt.bus_address = addr_sel & AddrMask;
    out_nxt.bus_data    = data_sel;
    out_nxt.last_cycle  = ctl.uw.last;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      addr_r <= in_data.target_address;
      word_r <= in_data.write_word;
    end
    if (ctl.emit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the parallel flash command sequencer.
`timescale 1ns / 1ps

module testbench;

  localparam logic [2:0] MODE_UNUSED_5 = 3'd5;
  localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

  localparam int PHASE_ITEMS = 100;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    pfcs_pkg::in_t  cmd;
    logic           typed;
    logic [1:0]     n_typed;
    pfcs_pkg::out_t first;
  } cmd_row_t;

  localparam int N_DIRECTED = 19;
  localparam cmd_row_t DIRECTED [N_DIRECTED] = '{
    '{'{pfcs_pkg::MODE_READ,     19'h00000, 16'hFFFF}, 1'b1, 2'd1,
      '{pfcs_pkg::KIND_READ, 19'h00000, 16'h0, 1'b1}},
    '{'{pfcs_pkg::MODE_READ,     19'h7FFFF, 16'h0000}, 1'b1, 2'd1,
      '{pfcs_pkg::KIND_READ, 19'h7FFFF, 16'h0, 1'b1}},
    '{'{pfcs_pkg::MODE_READ,     19'h2AAAA, 16'h5555}, 1'b1, 2'd1,
      '{pfcs_pkg::KIND_READ, 19'h2AAAA, 16'h0, 1'b1}},
    '{'{pfcs_pkg::MODE_READ,     19'h55555, 16'hAAAA}, 1'b1, 2'd1,
      '{pfcs_pkg::KIND_READ, 19'h55555, 16'h0, 1'b1}},
    '{'{pfcs_pkg::MODE_PROGRAM,  19'h00000, 16'h0000}, 1'b0, 2'd0, '0},
    '{'{pfcs_pkg::MODE_PROGRAM,  19'h7FFFF, 16'hFFFF}, 1'b0, 2'd0, '0},
    '{'{pfcs_pkg::MODE_PROGRAM,  19'h2AAAA, 16'hAAAA}, 1'b0, 2'd0, '0},
    '{'{pfcs_pkg::MODE_PROGRAM,  19'h55555, 16'h5555}, 1'b0, 2'd0, '0},
    '{'{pfcs_pkg::MODE_ERASE,    19'h7FFFF, 16'hFFFF}, 1'b0, 2'd0, '0},
    '{'{pfcs_pkg::MODE_IDENTIFY, 19'h7FFFF, 16'hFFFF}, 1'b0, 2'd0, '0},
    '{'{pfcs_pkg::MODE_EXIT,     19'h00000, 16'h0000}, 1'b0, 2'd0, '0},
    '{'{MODE_UNUSED_5,           19'h7FFFF, 16'hFFFF}, 1'b1, 2'd0, '0},
    '{'{MODE_UNUSED_6,           19'h00000, 16'h0000}, 1'b1, 2'd0, '0},
    '{'{MODE_UNUSED_7,           19'h12345, 16'hBEEF}, 1'b1, 2'd0, '0},
    '{'{pfcs_pkg::MODE_READ,     19'h00001, 16'h0001}, 1'b1, 2'd1,
      '{pfcs_pkg::KIND_READ, 19'h00001, 16'h0, 1'b1}},
    '{'{pfcs_pkg::MODE_IDENTIFY, 19'h00000, 16'h0000}, 1'b0, 2'd0, '0},
    '{'{pfcs_pkg::MODE_ERASE,    19'h00000, 16'h0000}, 1'b0, 2'd0, '0},
    '{'{pfcs_pkg::MODE_EXIT,     19'h7FFFF, 16'hFFFF}, 1'b0, 2'd0, '0},
    '{'{pfcs_pkg::MODE_PROGRAM,  19'h05555, 16'h1234}, 1'b0, 2'd0, '0}
  };

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  pfcs_pkg::in_t  in_data = '0;
  logic           busy;
  logic           out_valid;
  pfcs_pkg::out_t out_data;

  logic           row_typed = 1'b0;
  logic [1:0]     row_count = 2'd0;
  pfcs_pkg::out_t row_first = '0;

  pfcs_pkg::out_t bus_cycles_due[$];
  int   errors = 0;
  int   idle_pct = 0;

  always #5 clk = ~clk;

  parallel_flash_command_sequencer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  function automatic void add_bus_cycle(input logic [1:0] kind,
                                        input logic [pfcs_pkg::BUS_ADDR_W-1:0] addr,
                                        input logic [pfcs_pkg::DATA_W-1:0] data);
    pfcs_pkg::out_t c;
    c.cycle_kind  = kind;
    c.bus_address = addr;
    c.bus_data    = data;
    c.last_cycle  = 1'b0;
    bus_cycles_due.push_back(c);
  endfunction

  function automatic void add_unlock(input logic [7:0] code);
    add_bus_cycle(pfcs_pkg::KIND_WRITE, pfcs_pkg::UNLOCK_A,
                  {pfcs_pkg::CMD_AA, pfcs_pkg::CMD_AA});
    add_bus_cycle(pfcs_pkg::KIND_WRITE, pfcs_pkg::UNLOCK_B,
                  {pfcs_pkg::CMD_55, pfcs_pkg::CMD_55});
    add_bus_cycle(pfcs_pkg::KIND_WRITE, pfcs_pkg::UNLOCK_A, {code, code});
  endfunction

  function automatic void predict_bus_cycles(input pfcs_pkg::in_t c);
    int prior_count;
    prior_count = bus_cycles_due.size();
    case (c.mode)
      pfcs_pkg::MODE_READ: begin
        add_bus_cycle(pfcs_pkg::KIND_READ, c.target_address, '0);
      end
      pfcs_pkg::MODE_PROGRAM: begin
        add_unlock(pfcs_pkg::CMD_PROG);
        add_bus_cycle(pfcs_pkg::KIND_WRITE, c.target_address, c.write_word);
      end
      pfcs_pkg::MODE_ERASE: begin
        add_unlock(pfcs_pkg::CMD_ERASE);
        add_unlock(pfcs_pkg::CMD_CHIP);
        add_bus_cycle(pfcs_pkg::KIND_WAIT, '0, '0);
      end
      pfcs_pkg::MODE_IDENTIFY: begin
        add_unlock(pfcs_pkg::CMD_ID);
        add_bus_cycle(pfcs_pkg::KIND_READ, 19'h00000, '0);
        add_bus_cycle(pfcs_pkg::KIND_READ, 19'h00001, '0);
        add_unlock(pfcs_pkg::CMD_EXIT);
      end
      pfcs_pkg::MODE_EXIT: begin
        add_unlock(pfcs_pkg::CMD_EXIT);
      end
      default: ;
    endcase
    if (bus_cycles_due.size() > prior_count)
      bus_cycles_due[bus_cycles_due.size()-1].last_cycle = 1'b1;
  endfunction

  function automatic pfcs_pkg::in_t random_cmd();
    pfcs_pkg::in_t c;
    if ($urandom_range(99) < 8)
      c.mode = 3'($urandom_range(MODE_UNUSED_7, MODE_UNUSED_5));
    else
      c.mode = 3'($urandom_range(pfcs_pkg::MODE_EXIT, pfcs_pkg::MODE_READ));
    case ($urandom_range(5))
      0: c.target_address = '0;
      1: c.target_address = '1;
      default: c.target_address = 19'($urandom);
    endcase
    case ($urandom_range(5))
      0: c.write_word = '0;
      1: c.write_word = '1;
      default: c.write_word = 16'($urandom);
    endcase
    return c;
  endfunction

  always @(posedge clk) begin : bus_monitor
    pfcs_pkg::out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (bus_cycles_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected bus cycle kind %0d addr %h data %h last %b", $time,
                   out_data.cycle_kind, out_data.bus_address, out_data.bus_data,
                   out_data.last_cycle);
        end else begin
          want = bus_cycles_due.pop_front();
          if (out_data.cycle_kind !== want.cycle_kind ||
              out_data.bus_address !== want.bus_address ||
              out_data.bus_data !== want.bus_data ||
              out_data.last_cycle !== want.last_cycle) begin
            errors++;
            $display("%0t: expected kind %0d addr %h data %h last %b, got %0d %h %h %b",
                     $time, want.cycle_kind, want.bus_address, want.bus_data, want.last_cycle,
                     out_data.cycle_kind, out_data.bus_address, out_data.bus_data,
                     out_data.last_cycle);
          end
        end
      end
      if (start && !busy) begin
        if (!row_typed)
          predict_bus_cycles(in_data);
        else if (row_count != 2'd0)
          bus_cycles_due.push_back(row_first);
      end
    end
  end

  // Called just after a rising edge; returns at the edge that accepts the item.
  task automatic send_cmd(input pfcs_pkg::in_t c, input logic typed, input logic [1:0] n,
                          input pfcs_pkg::out_t first);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    in_data   <= c;
    row_typed <= typed;
    row_count <= n;
    row_first <= first;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (bus_cycles_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    pfcs_pkg::in_t c;
    int            n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 10;
    foreach (DIRECTED[i])
      send_cmd(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].n_typed, DIRECTED[i].first);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 10 : (phase == 1) ? 68 : 0;
      n = 0;
      while (n < PHASE_ITEMS) begin
        c = random_cmd();
        send_cmd(c, 1'b0, 2'd0, '0);
        n++;
      end
      if (phase == 1)
        drain();
    end
    drain();

    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
